>>> rtl/core/rrf_pkg.sv
// Shared types and constants for the renaming register file.
package rrf_pkg;

    localparam int CMD_W    = 3;
    localparam int REG_W    = 5;
    localparam int TAG_W    = 5;
    localparam int DATA_W   = 32;
    localparam int BYTE_W   = 8;
    // number of registers a REG_W-bit index can reach
    localparam int REG_SPAN = 32;
    // register whose low byte rides along with every result
    localparam int BYTE_REG = 10;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ_OPERAND = 3'd0,
        CMD_RAW_READ     = 3'd1,
        CMD_ISSUE        = 3'd2,
        CMD_COMMIT       = 3'd3,
        CMD_ADVANCE      = 3'd4,
        CMD_CLEAR        = 3'd5
    } t_cmd;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [REG_W-1:0]  reg_index;
        logic [TAG_W-1:0]  producer_tag;
        logic [DATA_W-1:0] commit_data;
    } t_in_word;

    typedef struct packed {
        logic              pending;
        logic [TAG_W-1:0]  pending_tag_out;
        logic [DATA_W-1:0] read_value;
        logic [BYTE_W-1:0] return_byte;
    } t_out_word;

endpackage

>>> rtl/core/rrf_if.sv
// Valid/ready channel interfaces for command and result words.
interface rrf_in_if import rrf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [REG_W-1:0]  reg_index;
    logic [TAG_W-1:0]  producer_tag;
    logic [DATA_W-1:0] commit_data;

    modport source (output valid, command, reg_index, producer_tag, commit_data,
                    input ready);
    modport sink   (input valid, command, reg_index, producer_tag, commit_data,
                    output ready);
endinterface

interface rrf_out_if import rrf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              pending;
    logic [TAG_W-1:0]  pending_tag_out;
    logic [DATA_W-1:0] read_value;
    logic [BYTE_W-1:0] return_byte;

    modport source (output valid, pending, pending_tag_out, read_value, return_byte,
                    input ready);
    modport sink   (input valid, pending, pending_tag_out, read_value, return_byte,
                    output ready);
endinterface

>>> rtl/core/rrf_in_reg.sv
// Input register: captures one command word and holds it until executed.
module rrf_in_reg import rrf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    rrf_in_if.sink   s_in,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_word o_word
);

    logic     r_valid;
    logic     n_valid;
    t_in_word r_word;
    logic     accept;

    assign s_in.ready = !r_valid || i_take;
    assign accept     = s_in.valid && s_in.ready;

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word.command      <= s_in.command;
            r_word.reg_index    <= s_in.reg_index;
            r_word.producer_tag <= s_in.producer_tag;
            r_word.commit_data  <= s_in.commit_data;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

>>> rtl/core/rrf_table.sv
// Register status table: current/next values and tags, update and read logic.
module rrf_table import rrf_pkg::*; #(
    parameter int NUM_REGS  = 32,
    parameter int TAG_COUNT = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_word  i_word,
    output t_out_word o_word
);

    // registers beyond the index span can never be addressed or observed
    localparam int NR = (NUM_REGS < REG_SPAN) ? NUM_REGS : REG_SPAN;
    localparam int IW = $clog2(NR);
    localparam logic [REG_W:0] NR_LIMIT = (REG_W+1)'(NR);

    logic [DATA_W-1:0] r_cur_val [NR];
    logic [DATA_W-1:0] r_nxt_val [NR];
    logic [TAG_W-1:0]  r_cur_tag [NR];
    logic [TAG_W-1:0]  r_nxt_tag [NR];
    logic [NR-1:0]     r_cur_busy;
    logic [NR-1:0]     r_nxt_busy;
    logic [NR-1:0]     r_reiss;

    logic [DATA_W-1:0] n_cur_val [NR];
    logic [DATA_W-1:0] n_nxt_val [NR];
    logic [TAG_W-1:0]  n_cur_tag [NR];
    logic [TAG_W-1:0]  n_nxt_tag [NR];
    logic [NR-1:0]     n_cur_busy;
    logic [NR-1:0]     n_nxt_busy;
    logic [NR-1:0]     n_reiss;

    logic [TAG_W-1:0]  tag_lut [REG_SPAN];
    logic [TAG_W-1:0]  tag_mod;
    logic              hit;
    logic [IW-1:0]     idx;
    logic              drop;
    logic [BYTE_W-1:0] ret_byte;

    // tag reduced modulo TAG_COUNT through a constant table
    for (genvar g = 0; g < REG_SPAN; g++) begin : g_tag_lut
        assign tag_lut[g] = TAG_W'(g % TAG_COUNT);
    end

    assign tag_mod = tag_lut[i_word.producer_tag];
    assign hit     = ({1'b0, i_word.reg_index} < NR_LIMIT) && (i_word.reg_index != '0);
    assign idx     = i_word.reg_index[IW-1:0];
    assign drop    = (i_word.command == CMD_CLEAR);

    always_comb begin
        n_cur_val  = r_cur_val;
        n_nxt_val  = r_nxt_val;
        n_cur_tag  = r_cur_tag;
        n_nxt_tag  = r_nxt_tag;
        n_cur_busy = r_cur_busy;
        n_nxt_busy = r_nxt_busy;
        n_reiss    = r_reiss;
        if (i_fire) begin
            unique case (i_word.command)
                CMD_ISSUE: begin
                    if (hit) begin
                        n_nxt_busy[idx] = 1'b1;
                        n_nxt_tag[idx]  = tag_mod;
                        n_reiss[idx]    = 1'b1;
                    end
                end
                CMD_COMMIT: begin
                    if (hit) begin
                        n_nxt_val[idx] = i_word.commit_data;
                        if (r_cur_busy[idx] && (r_cur_tag[idx] == tag_mod)
                            && !r_reiss[idx]) begin
                            n_nxt_busy[idx] = 1'b0;
                            n_nxt_tag[idx]  = '0;
                        end
                    end
                end
                CMD_ADVANCE, CMD_CLEAR: begin
                    for (int i = 0; i < NR; i++) begin
                        n_cur_val[i] = r_nxt_val[i];
                        if (drop) begin
                            n_nxt_busy[i] = 1'b0;
                            n_nxt_tag[i]  = '0;
                            n_cur_busy[i] = 1'b0;
                            n_cur_tag[i]  = '0;
                        end else begin
                            n_cur_busy[i] = r_nxt_busy[i];
                            n_cur_tag[i]  = r_nxt_tag[i];
                        end
                    end
                    n_reiss = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NR; i++) begin
                r_cur_val[i] <= '0;
                r_nxt_val[i] <= '0;
                r_cur_tag[i] <= '0;
                r_nxt_tag[i] <= '0;
            end
            r_cur_busy <= '0;
            r_nxt_busy <= '0;
            r_reiss    <= '0;
        end else begin
            r_cur_val  <= n_cur_val;
            r_nxt_val  <= n_nxt_val;
            r_cur_tag  <= n_cur_tag;
            r_nxt_tag  <= n_nxt_tag;
            r_cur_busy <= n_cur_busy;
            r_nxt_busy <= n_nxt_busy;
            r_reiss    <= n_reiss;
        end
    end

    // reads see the state before this word; reads do not modify it
    always_comb begin
        o_word.pending         = 1'b0;
        o_word.pending_tag_out = '0;
        o_word.read_value      = '0;
        o_word.return_byte     = ret_byte;
        unique case (i_word.command)
            CMD_READ_OPERAND: begin
                if (hit) begin
                    if (r_cur_busy[idx]) begin
                        o_word.pending         = 1'b1;
                        o_word.pending_tag_out = r_cur_tag[idx];
                        o_word.read_value      = '1;
                    end else begin
                        o_word.read_value = r_cur_val[idx];
                    end
                end
            end
            CMD_RAW_READ: begin
                if (hit) begin
                    o_word.read_value = r_cur_val[idx];
                end
            end
            default: begin
            end
        endcase
    end

    // low byte is taken after this word's update
    if (NR > BYTE_REG) begin : g_byte
        assign ret_byte = n_cur_val[BYTE_REG][BYTE_W-1:0];
    end else begin : g_no_byte
        assign ret_byte = '0;
    end

`ifndef SYNTH
    a_reg0_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cur_busy[0] && !r_nxt_busy[0] && (r_cur_val[0] == '0))
        else $error("register zero became pending or nonzero");

    a_marks_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (i_word.command == CMD_ADVANCE || i_word.command == CMD_CLEAR))
        |=> (r_reiss == '0))
        else $error("reissue marks survived an advance");

    a_clear_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_word.command == CMD_CLEAR)
        |=> (r_cur_busy == '0) && (r_nxt_busy == '0))
        else $error("pending tag survived a clear");

    a_pend_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_word.pending |-> (o_word.read_value == '1)
                           && (i_word.command == CMD_READ_OPERAND))
        else $error("pending result without all-ones operand read");
`endif

endmodule

>>> rtl/core/rrf_out_reg.sv
// Output register: holds a result word until the receiver takes it.
module rrf_out_reg import rrf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_out_word i_word,
    output logic      o_take,
    rrf_out_if.source m_out
);

    logic      r_valid;
    logic      n_valid;
    t_out_word r_word;

    assign o_take = i_valid && (!r_valid || m_out.ready);

    always_comb begin
        if (o_take) begin
            n_valid = 1'b1;
        end else if (m_out.ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_word <= i_word;
        end
    end

    assign m_out.valid           = r_valid;
    assign m_out.pending         = r_word.pending;
    assign m_out.pending_tag_out = r_word.pending_tag_out;
    assign m_out.read_value      = r_word.read_value;
    assign m_out.return_byte     = r_word.return_byte;

endmodule

>>> rtl/core/renaming_register_file_top.sv
// Top level of the renaming register file with per-register producer tags.
//
// Command words arrive on i_in (valid/ready): read operand, raw read, issue,
// commit, advance and clear, with register index, producer tag and commit data.
// Every word yields exactly one result word on o_out (valid/ready): pending
// flag, producer tag, register value and the low byte of register 10 as it
// stands after the word is applied.
//
// A word waits in the input register until the output register can take its
// result; the table update and the result capture then happen at the same edge.
// One word per cycle is sustained while the receiver does not stall; the table
// updates and the result are a single short pass between the two registers.
//
// When the receiver stalls, the output register holds its word and the input
// register still takes one more word; ready then drops until the output
// drains. Reset (i_rst_n low, synchronous) empties both registers and sets
// every value to zero and every register to not pending.
module renaming_register_file_top import rrf_pkg::*; #(
    parameter int NUM_REGS  = 32,
    parameter int TAG_COUNT = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rrf_in_if.sink    i_in,
    rrf_out_if.source o_out
);

    logic      s1_valid;
    t_in_word  s1_word;
    logic      take;
    t_out_word res_word;

    rrf_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (i_in),
        .i_take  (take),
        .o_valid (s1_valid),
        .o_word  (s1_word)
    );

    rrf_table #(
        .NUM_REGS  (NUM_REGS),
        .TAG_COUNT (TAG_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (take),
        .i_word  (s1_word),
        .o_word  (res_word)
    );

    rrf_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_word  (res_word),
        .o_take  (take),
        .m_out   (o_out)
    );

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the renaming register file: random and directed command words.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rrf_pkg::*;

    localparam int NUM_REGS    = 32;
    localparam int TAG_COUNT   = 32;
    localparam int RANDOM_WORDS = 1925;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;
    // command codes the block treats as no-ops
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rrf_in_if  cmd_if ();
    rrf_out_if res_if ();

    renaming_register_file_top #(
        .NUM_REGS  (NUM_REGS),
        .TAG_COUNT (TAG_COUNT)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the register table
    logic [DATA_W-1:0] cur_val  [NUM_REGS];
    logic [DATA_W-1:0] nxt_val  [NUM_REGS];
    logic              cur_busy [NUM_REGS];
    logic              nxt_busy [NUM_REGS];
    logic [TAG_W-1:0]  cur_tag  [NUM_REGS];
    logic [TAG_W-1:0]  nxt_tag  [NUM_REGS];
    logic              reissued [NUM_REGS];

    t_in_word  pending_words [$];
    t_out_word table_results [$];
    logic [TAG_W-1:0] last_issue_tag [NUM_REGS];

    int  words_sent = 0;
    int  words_checked = 0;
    int  mismatches = 0;
    int  quiet_cycles = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    logic calm_stretch;

    assign calm_stretch = (words_sent >= 1100) && (words_sent < 1400);

    function automatic void copy_next_to_current(input bit drop_tags);
        for (int i = 1; i < NUM_REGS; i++) begin
            cur_val[i] = nxt_val[i];
            if (drop_tags) begin
                nxt_busy[i] = 1'b0;
                nxt_tag[i]  = '0;
            end
            cur_busy[i] = nxt_busy[i];
            cur_tag[i]  = nxt_tag[i];
            reissued[i] = 1'b0;
        end
        cur_val[0]  = '0;
        nxt_val[0]  = '0;
        cur_busy[0] = 1'b0;
        cur_tag[0]  = '0;
        nxt_busy[0] = 1'b0;
        nxt_tag[0]  = '0;
        reissued[0] = 1'b0;
    endfunction

    // applies one command word to the shadow table and returns its result word
    function automatic t_out_word apply_table_cmd(input t_in_word w);
        t_out_word res;
        int r;
        logic [TAG_W-1:0] tag;
        bit live;
        r    = w.reg_index;
        tag  = TAG_W'(int'(w.producer_tag) % TAG_COUNT);
        live = (r < NUM_REGS) && (r != 0);
        res  = '0;
        case (w.command)
            CMD_READ_OPERAND: begin
                if (live) begin
                    if (cur_busy[r]) begin
                        res.pending         = 1'b1;
                        res.pending_tag_out = cur_tag[r];
                        res.read_value      = '1;
                    end else begin
                        res.read_value = cur_val[r];
                    end
                end
            end
            CMD_RAW_READ: begin
                if (live) res.read_value = cur_val[r];
            end
            CMD_ISSUE: begin
                if (live) begin
                    nxt_busy[r] = 1'b1;
                    nxt_tag[r]  = tag;
                    reissued[r] = 1'b1;
                end
            end
            CMD_COMMIT: begin
                if (live) begin
                    nxt_val[r] = w.commit_data;
                    if (cur_busy[r] && cur_tag[r] == tag && !reissued[r]) begin
                        nxt_busy[r] = 1'b0;
                        nxt_tag[r]  = '0;
                    end
                end
            end
            CMD_ADVANCE: copy_next_to_current(1'b0);
            CMD_CLEAR:   copy_next_to_current(1'b1);
            default: ;
        endcase
        res.return_byte = (BYTE_REG < NUM_REGS) ? cur_val[BYTE_REG][BYTE_W-1:0] : '0;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // command driver
    always @(posedge i_clk) begin : cmd_driver
        t_in_word w;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                w.command      = cmd_if.command;
                w.reg_index    = cmd_if.reg_index;
                w.producer_tag = cmd_if.producer_tag;
                w.commit_data  = cmd_if.commit_data;
                table_results.push_back(apply_table_cmd(w));
                words_sent++;
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (pending_words.size() != 0 &&
                    (calm_stretch || $urandom_range(99) >= 35)) begin
                    w = pending_words.pop_front();
                    cmd_if.valid        <= 1'b1;
                    cmd_if.command      <= w.command;
                    cmd_if.reg_index    <= w.reg_index;
                    cmd_if.producer_tag <= w.producer_tag;
                    cmd_if.commit_data  <= w.commit_data;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin : res_monitor
        t_out_word want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (table_results.size() == 0) begin
                    $display("%0t: result word with none expected, actual %b %h %h %h", $time,
                             res_if.pending, res_if.pending_tag_out, res_if.read_value,
                             res_if.return_byte);
                    mismatches++;
                end else begin
                    want = table_results.pop_front();
                    check_field("pending", 32'(want.pending), 32'(res_if.pending));
                    check_field("pending_tag_out", 32'(want.pending_tag_out),
                                32'(res_if.pending_tag_out));
                    check_field("read_value", want.read_value, res_if.read_value);
                    check_field("return_byte", 32'(want.return_byte),
                                32'(res_if.return_byte));
                end
                words_checked++;
            end
            if (hold_left != 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (!hold_done && words_checked >= 400) begin
                // long back-pressure so the block fills and drops its input ready
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= calm_stretch || ($urandom_range(99) >= 35);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_word(input logic [CMD_W-1:0] cmd, input logic [REG_W-1:0] r,
                              input logic [TAG_W-1:0] tag, input logic [DATA_W-1:0] data);
        t_in_word w;
        w.command      = cmd;
        w.reg_index    = r;
        w.producer_tag = tag;
        w.commit_data  = data;
        pending_words.push_back(w);
    endtask

    task automatic queue_random_word();
        int pick;
        logic [CMD_W-1:0]  cmd;
        logic [REG_W-1:0]  r;
        logic [TAG_W-1:0]  tag;
        logic [DATA_W-1:0] data;
        pick = $urandom_range(99);
        if (pick < 28)      cmd = CMD_READ_OPERAND;
        else if (pick < 38) cmd = CMD_RAW_READ;
        else if (pick < 58) cmd = CMD_ISSUE;
        else if (pick < 83) cmd = CMD_COMMIT;
        else if (pick < 93) cmd = CMD_ADVANCE;
        else if (pick < 96) cmd = CMD_CLEAR;
        else                cmd = ($urandom_range(1) != 0) ? CMD_SPARE_7 : CMD_SPARE_6;
        // mostly a small register set so issues and commits collide
        r   = ($urandom_range(3) == 0) ? REG_W'($urandom_range(31)) : REG_W'($urandom_range(11, 1));
        tag = TAG_W'($urandom_range(31));
        case ($urandom_range(9))
            0:       data = '0;
            1:       data = '1;
            default: data = $urandom;
        endcase
        if (cmd == CMD_ISSUE) last_issue_tag[r] = tag;
        if (cmd == CMD_COMMIT && $urandom_range(9) < 7) tag = last_issue_tag[r];
        queue_word(cmd, r, tag, data);
    endtask

    initial begin
        cmd_if.valid        = 1'b0;
        cmd_if.command      = '0;
        cmd_if.reg_index    = '0;
        cmd_if.producer_tag = '0;
        cmd_if.commit_data  = '0;
        res_if.ready        = 1'b0;
        for (int i = 0; i < NUM_REGS; i++) begin
            cur_val[i]  = '0;
            nxt_val[i]  = '0;
            cur_busy[i] = 1'b0;
            nxt_busy[i] = 1'b0;
            cur_tag[i]  = '0;
            nxt_tag[i]  = '0;
            reissued[i] = 1'b0;
            last_issue_tag[i] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: register zero, wrong and right tags, return byte extremes,
        // clear, spare commands
        queue_word(CMD_READ_OPERAND, 5'd0,  5'd0,  32'h0);
        queue_word(CMD_RAW_READ,     5'd31, 5'd31, 32'hFFFF_FFFF);
        queue_word(CMD_ISSUE,        5'd10, 5'd31, 32'h0);
        queue_word(CMD_COMMIT,       5'd10, 5'd31, 32'hFFFF_FFFF);
        queue_word(CMD_READ_OPERAND, 5'd10, 5'd0,  32'h0);
        queue_word(CMD_ADVANCE,      5'd0,  5'd0,  32'h0);
        queue_word(CMD_READ_OPERAND, 5'd10, 5'd0,  32'h0);
        queue_word(CMD_RAW_READ,     5'd10, 5'd0,  32'h0);
        queue_word(CMD_COMMIT,       5'd10, 5'd30, 32'h0);
        queue_word(CMD_ADVANCE,      5'd0,  5'd0,  32'h0);
        queue_word(CMD_READ_OPERAND, 5'd10, 5'd0,  32'h0);
        queue_word(CMD_COMMIT,       5'd10, 5'd31, 32'h5A5A_A5A5);
        queue_word(CMD_ADVANCE,      5'd0,  5'd0,  32'h0);
        queue_word(CMD_READ_OPERAND, 5'd10, 5'd0,  32'h0);
        queue_word(CMD_ISSUE,        5'd0,  5'd7,  32'h0);
        queue_word(CMD_COMMIT,       5'd0,  5'd7,  32'h1234_5678);
        queue_word(CMD_ISSUE,        5'd31, 5'd0,  32'h0);
        queue_word(CMD_ISSUE,        5'd5,  5'd17, 32'h0);
        queue_word(CMD_ADVANCE,      5'd0,  5'd0,  32'h0);
        queue_word(CMD_READ_OPERAND, 5'd31, 5'd0,  32'h0);
        queue_word(CMD_CLEAR,        5'd0,  5'd0,  32'h0);
        queue_word(CMD_READ_OPERAND, 5'd31, 5'd0,  32'h0);
        queue_word(CMD_READ_OPERAND, 5'd5,  5'd0,  32'h0);
        queue_word(CMD_SPARE_6,      5'd31, 5'd31, 32'hFFFF_FFFF);
        queue_word(CMD_SPARE_7,      5'd10, 5'd0,  32'h0);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            // sender pauses until the table has answered everything so far
            if (n == 0 || n == 1000) begin
                while (pending_words.size() != 0 || cmd_if.valid || table_results.size() != 0)
                    @(negedge i_clk);
            end
            queue_random_word();
        end

        while (pending_words.size() != 0 || cmd_if.valid || table_results.size() != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
